/* src/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the buddy block allocator
// Level count, field widths, codes and the control bundle to the level cells.
// ----------------------------------------------------------------------------
package bba_pkg;

  // pool geometry
  localparam int MAX_LEVEL = 40;
  localparam int LEVELS    = MAX_LEVEL + 1;
  localparam int ADDR_W    = 48;
  localparam int OPND_W    = ADDR_W + 1;
  localparam int LVL_W     = 6;
  localparam int HDR_W     = 5;
  localparam int CFG_W     = 6;
  localparam int RSV_W     = 12;

  // opcodes
  localparam logic OP_INIT  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // register indexes
  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_MINLVL = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOBLK  = 2'd1;
  localparam logic [1:0] ST_TOOBIG = 2'd2;

  // command to every level cell
  typedef enum logic [2:0] {
    CC_NONE,
    CC_CMP,
    CC_CLEAR,
    CC_PLACE,
    CC_COMMIT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [OPND_W-1:0]   operand;
    logic [ADDR_W-1:0]   base;
  } cell_ctl_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CMP,
    S_PLACE,
    S_PICK,
    S_COMMIT,
    S_OUT
  } seq_state_t;

endpackage

/* src/bba_cell.sv */
// ----------------------------------------------------------------------------
// bba_cell: one level of the allocator
// Holds the free flag and free block address of its level, compares the
// broadcast operand against its block size and talks to its neighbors.
// ----------------------------------------------------------------------------
module bba_cell
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [LVL_W-1:0]  cell_level,
  input  logic [LVL_W-1:0]  min_level,
  input  cell_ctl_t         ctl,
  input  logic              found,
  input  logic              split,
  input  logic              lo_elig_i,
  input  logic              hi_lt_i,
  output logic              lt_o,
  output logic              elig_o,
  output logic              first_o,
  output logic              has_free_o,
  output logic [ADDR_W-1:0] addr_o
);

  logic              lt_r;
  logic              has_free_r;
  logic [ADDR_W-1:0] addr_r;
  logic [OPND_W-1:0] size_w;
  logic [ADDR_W-1:0] buddy_w;
  logic              top_w;

  // block size of this level and address of the buddy left by a split
  assign size_w  = OPND_W'(1) << cell_level;
  assign buddy_w = ctl.base | (ADDR_W'(1) << cell_level);

  // operand below the block size of this level
  always_ff @(posedge clk) begin
    if (ctl.cmd == CC_CMP) begin
      lt_r <= (ctl.operand < size_w);
    end
  end

  // free flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_free_r <= 1'b0;
    end else begin
      unique case (ctl.cmd)
        CC_CLEAR:  has_free_r <= 1'b0;
        CC_PLACE:  has_free_r <= top_w;
        CC_COMMIT: begin
          if (found) begin
            has_free_r <= 1'b0;
          end else if (split) begin
            has_free_r <= 1'b1;
          end
        end
        default:   has_free_r <= has_free_r;
      endcase
    end
  end

  // free block address
  always_ff @(posedge clk) begin
    if (ctl.cmd == CC_PLACE && top_w) begin
      addr_r <= '0;
    end else if (ctl.cmd == CC_COMMIT && split && !found) begin
      addr_r <= buddy_w;
    end
  end

  // level fits the request and is allowed
  assign elig_o     = lt_r && (cell_level >= min_level) && (cell_level != '0);
  // smallest allowed level: lower neighbor not eligible
  assign first_o    = elig_o && !lo_elig_i;
  // pool level: size reaches this level but not the next
  assign top_w      = !lt_r && hi_lt_i;
  assign lt_o       = lt_r;
  assign has_free_o = has_free_r;
  assign addr_o     = addr_r;

endmodule

/* src/buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator: alloc-only buddy allocator over a pool of units
// Sequencer plus a row of level cells, one per level 0..MAX_LEVEL.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      in_valid/in_ready  in_opcode, in_request_units
//  out      output     out_valid/out_ready out_block_index, out_granted_level,
//                                          out_status
//  cfg      input      cfg_we             cfg_index, cfg_wdata
//
//  allocate: an accepted beat runs prepare, cell compare, pick, commit and
//  output; init runs the place step and then the reservation allocation
//  through the same path; init on an empty pool goes from prepare to output.
//  allocate and init share the single compare/pick/commit sequence.
//  one beat is worked on at a time; in_ready is high only when idle.
//  a finished result waits in the output register while the next beat is
//  accepted; only the final output step stalls on out_ready.
//  synchronous reset clears all free flags and loads register defaults.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [ADDR_W-1:0] in_request_units,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_block_index,
  output logic [LVL_W-1:0]  out_granted_level,
  output logic [1:0]        out_status
);

  seq_state_t state_r, state_nxt;

  logic [HDR_W-1:0]  header_r;
  logic [LVL_W-1:0]  min_level_r;

  logic              op_r;
  logic [ADDR_W-1:0] req_r;
  logic [OPND_W-1:0] operand_r, operand_nxt;
  logic [LEVELS-1:0] found_r, split_r;
  logic [ADDR_W-1:0] base_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [1:0]        status_r;
  logic [ADDR_W-1:0] res_index_r;
  logic [LVL_W-1:0]  res_level_r;
  logic [1:0]        res_status_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_index_r;
  logic [LVL_W-1:0]  out_level_r;
  logic [1:0]        out_status_r;

  cell_ctl_t         ctl;
  logic [LEVELS-1:0] lt_v, elig_v, first_v, free_v;
  logic [ADDR_W-1:0] addr_v [LEVELS];

  logic [OPND_W-1:0] need_m1_w, avail_w;
  logic              empty_w;
  logic [RSV_W-1:0]  rsv_w;
  logic [LEVELS-1:0] cand_w, found_w, split_w;
  logic [ADDR_W-1:0] base_w;
  logic [LVL_W-1:0]  lvl_w;
  logic [1:0]        status_w;
  logic              out_load_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= HDR_W'(1);
      min_level_r <= LVL_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER: header_r    <= cfg_wdata[HDR_W-1:0];
        CFG_MINLVL: min_level_r <= cfg_wdata[LVL_W-1:0];
        default:    header_r    <= header_r;
      endcase
    end
  end

  // row of level cells
  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    logic lo_elig, hi_lt;
    if (g == 0) begin : g_lo
      assign lo_elig = 1'b0;
    end else begin : g_lo
      assign lo_elig = elig_v[g-1];
    end
    if (g == LEVELS - 1) begin : g_hi
      assign hi_lt = 1'b1;
    end else begin : g_hi
      assign hi_lt = lt_v[g+1];
    end
    bba_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_level (LVL_W'(g)),
      .min_level  (min_level_r),
      .ctl        (ctl),
      .found      (found_r[g]),
      .split      (split_r[g]),
      .lo_elig_i  (lo_elig),
      .hi_lt_i    (hi_lt),
      .lt_o       (lt_v[g]),
      .elig_o     (elig_v[g]),
      .first_o    (first_v[g]),
      .has_free_o (free_v[g]),
      .addr_o     (addr_v[g])
    );
  end

  // request plus header minus one, and pool size minus header
  assign need_m1_w = (header_r == '0 && req_r == '0) ? '0 :
                     {1'b0, req_r} + OPND_W'(header_r) - OPND_W'(1);
  assign avail_w   = {1'b0, req_r} - OPND_W'(header_r);
  assign empty_w   = ({1'b0, req_r} <= OPND_W'(header_r));
  assign rsv_w     = RSV_W'(header_r) * RSV_W'(MAX_LEVEL - 1);

  // pick: lowest eligible free level, buddies below it, its address
  assign cand_w  = elig_v & free_v;
  assign found_w = cand_w & (~cand_w + LEVELS'(1));
  assign split_w = (cand_w != '0) ? (elig_v & (found_w - LEVELS'(1))) : '0;

  always_comb begin
    base_w = '0;
    lvl_w  = '0;
    for (int l = 0; l < LEVELS; l++) begin
      base_w = base_w | (found_w[l] ? addr_v[l] : '0);
      lvl_w  = lvl_w  | (first_v[l] ? LVL_W'(l) : '0);
    end
  end

  always_comb begin
    if (elig_v == '0) begin
      status_w = ST_TOOBIG;
    end else if (cand_w == '0) begin
      status_w = ST_NOBLK;
    end else begin
      status_w = ST_OK;
    end
  end

  assign out_load_w = !out_valid_r || out_ready;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer next state and cell commands
  always_comb begin
    state_nxt   = state_r;
    ctl.cmd     = CC_NONE;
    ctl.operand = operand_r;
    ctl.base    = base_r;
    operand_nxt = operand_r;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (op_r == OP_INIT) begin
          if (empty_w) begin
            ctl.cmd   = CC_CLEAR;
            state_nxt = S_OUT;
          end else begin
            operand_nxt = avail_w;
            state_nxt   = S_CMP;
          end
        end else begin
          operand_nxt = need_m1_w;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        ctl.cmd   = CC_CMP;
        state_nxt = (op_r == OP_INIT) ? S_PLACE : S_PICK;
      end
      S_PLACE: begin
        ctl.cmd   = CC_PLACE;
        state_nxt = S_PREP;
      end
      S_PICK: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        ctl.cmd   = CC_COMMIT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load_w) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // job and datapath registers
  always_ff @(posedge clk) begin
    operand_r <= operand_nxt;
    if (state_r == S_IDLE && in_valid) begin
      op_r  <= in_opcode;
      req_r <= in_request_units;
    end
    // init turns into the reservation allocation
    if (state_r == S_PLACE) begin
      op_r  <= OP_ALLOC;
      req_r <= ADDR_W'(rsv_w);
    end
    if (state_r == S_PICK) begin
      found_r  <= found_w;
      split_r  <= split_w;
      base_r   <= base_w;
      lvl_r    <= lvl_w;
      status_r <= status_w;
    end else if (state_r == S_COMMIT) begin
      found_r <= '0;
      split_r <= '0;
    end
    // result of this beat
    if (state_r == S_PREP && op_r == OP_INIT && empty_w) begin
      res_index_r  <= '0;
      res_level_r  <= '0;
      res_status_r <= ST_NOBLK;
    end else if (state_r == S_COMMIT) begin
      res_index_r  <= (status_r == ST_OK) ? base_r + ADDR_W'(header_r) : '0;
      res_level_r  <= (status_r == ST_OK) ? lvl_r : '0;
      res_status_r <= status_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_load_w) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_load_w) begin
      out_index_r  <= res_index_r;
      out_level_r  <= res_level_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_index   = out_index_r;
  assign out_granted_level = out_level_r;
  assign out_status        = out_status_r;

endmodule
